>>> rtl/tmr_pkg.sv
// shared types and constants for the prescaled up-counter timer
package tmr_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MAX_LO = 3'd2;
	localparam logic [2:0] REG_MAX_HI = 3'd3;
	localparam logic [2:0] REG_CNT_LO = 3'd4;
	localparam logic [2:0] REG_CNT_HI = 3'd5;
	localparam logic [2:0] REG_DIV    = 3'd6;

	localparam int CTRL_ENABLE_BIT = 0;
	localparam int CTRL_RETRIG_BIT = 1;
	localparam int CTRL_IRQ_EN_BIT = 8;

	typedef struct packed {
		op_t         op;
		logic [2:0]  reg_index;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_level;
	} rsp_t;

	typedef struct packed {
		logic enable;
		logic irq_pending;
	} stat_t;

endpackage

>>> rtl/tmr_in_reg.sv
// input register holding one accepted request
module tmr_in_reg import tmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       req_in,
	input  logic       adv,
	output logic       req_valid,
	output req_t       req_out
);

	logic req_valid_s1;
	req_t req_s1;

	assign in_ready  = !req_valid_s1 || adv;
	assign req_valid = req_valid_s1;
	assign req_out   = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			req_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_in;
		end
	end

endmodule

>>> rtl/tmr_core.sv
// timer state and single-pass request update
module tmr_core import tmr_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  req_t  req,
	output rsp_t  rsp,
	output stat_t stat
);

	localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_BITS) - 64'd1);

	logic [15:0]           ctrl_q, ctrl_d;
	logic [31:0]           max_q, max_d;
	logic [15:0]           div_q, div_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [15:0]           phase_q, phase_d;
	logic [15:0]           latch_q, latch_d;
	logic                  irq_q, irq_d;

	logic [31:0]           cnt_ext;
	logic                  full_wrap;
	logic                  max_wrap;
	logic [COUNT_BITS-1:0] cnt_adv;
	logic [15:0]           rd;

	assign cnt_ext   = 32'(cnt_q);
	assign full_wrap = (max_q == 32'd0) || (max_q >= CNT_MASK);
	assign max_wrap  = !full_wrap && (cnt_ext >= max_q);
	assign cnt_adv   = max_wrap ? '0 : cnt_q + COUNT_BITS'(1);

	always_comb begin
		ctrl_d  = ctrl_q;
		max_d   = max_q;
		div_d   = div_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		latch_d = latch_q;
		irq_d   = irq_q;
		rd      = 16'd0;
		case (req.op)
			OP_TICK: begin
				if (ctrl_q[CTRL_ENABLE_BIT]) begin
					if (phase_q >= div_q) begin
						phase_d = 16'd0;
						cnt_d   = cnt_adv;
						if (ctrl_q[CTRL_IRQ_EN_BIT] && (max_q != 32'd0) &&
						    (32'(cnt_adv) == max_q)) begin
							irq_d = 1'b1;
						end
					end else begin
						phase_d = phase_q + 16'd1;
					end
				end
			end
			OP_READ: begin
				case (req.reg_index)
					REG_CTRL:   rd = ctrl_q;
					REG_MAX_LO: rd = max_q[15:0];
					REG_MAX_HI: rd = max_q[31:16];
					REG_CNT_LO: begin
						rd      = cnt_ext[15:0];
						latch_d = cnt_ext[31:16];
					end
					REG_CNT_HI: rd = latch_q;
					REG_DIV:    rd = div_q;
					default:    rd = 16'd0;
				endcase
			end
			OP_WRITE: begin
				case (req.reg_index)
					REG_CTRL: begin
						if (req.write_data[CTRL_RETRIG_BIT] ||
						    (!ctrl_q[CTRL_ENABLE_BIT] && req.write_data[CTRL_ENABLE_BIT])) begin
							cnt_d = '0;
						end
						ctrl_d                  = req.write_data;
						ctrl_d[CTRL_RETRIG_BIT] = 1'b0;
						phase_d                 = 16'd0;
						irq_d                   = 1'b0;
					end
					REG_MAX_LO: max_d[15:0]  = req.write_data;
					REG_MAX_HI: max_d[31:16] = req.write_data;
					REG_DIV:    div_d        = req.write_data;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign rsp.read_data    = rd;
	assign rsp.irq_level    = irq_d;
	assign stat.enable      = ctrl_q[CTRL_ENABLE_BIT];
	assign stat.irq_pending = irq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= 16'd0;
			max_q   <= 32'd0;
			div_q   <= 16'd0;
			cnt_q   <= '0;
			phase_q <= 16'd0;
			latch_q <= 16'd0;
			irq_q   <= 1'b0;
		end else if (go) begin
			ctrl_q  <= ctrl_d;
			max_q   <= max_d;
			div_q   <= div_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			latch_q <= latch_d;
			irq_q   <= irq_d;
		end
	end

endmodule

>>> rtl/tmr_out_reg.sv
// result register on the output channel
module tmr_out_reg import tmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t rsp_in,
	input  logic out_ready,
	output logic out_valid,
	output rsp_t rsp_out
);

	logic out_valid_q;
	rsp_t rsp_q;

	assign out_valid = out_valid_q;
	assign rsp_out   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_in;
		end
	end

endmodule

>>> rtl/prescaled_up_counter_timer_unit.sv
// top level of the prescaled up-counter timer with compare interrupt
// each request is a source tick, a 16-bit register read or a register write, and each
// gives exactly one response carrying read data and the interrupt level after it.
// requests go into an input register, the timer state is updated by one short pass of
// logic from there, and the response lands in an output register; a new request is taken
// every clock while responses are drained, and the sustained rate is one request per cycle,
// set by the single state update per clock. a response is valid once its request has passed
// from the input register to the output register. a response left waiting holds the request
// behind it, and the input stalls once both registers are full.
// registers: 0 control (bit 0 enable, bit 1 retrigger, self-clearing, bit 8 interrupt
// enable), 2/3 max low/high, 4 counter low (latches the high half), 5 latched high half,
// 6 divide; 1 and 7 read zero. the counter advances once per divide+1 enabled ticks and
// wraps after max, or at full width when max is zero or at least the counter's all-ones value.
module prescaled_up_counter_timer_unit import tmr_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  reg_index,
	input  logic [15:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic        irq_level
);

	req_t  req_in;
	req_t  req_s1;
	logic  req_valid;
	logic  adv;
	rsp_t  rsp_core;
	rsp_t  rsp_out;
	stat_t stat;

	// pack the incoming request
	assign req_in.op         = op_t'(op);
	assign req_in.reg_index  = reg_index;
	assign req_in.write_data = write_data;

	// the held request moves on whenever the result slot is free or being drained
	assign adv = req_valid && (!out_valid || out_ready);

	tmr_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_in    (req_in),
		.adv       (adv),
		.req_valid (req_valid),
		.req_out   (req_s1)
	);

	// timer state, updated once per request
	tmr_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv),
		.req    (req_s1),
		.rsp    (rsp_core),
		.stat   (stat)
	);

	tmr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.rsp_in    (rsp_core),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.rsp_out   (rsp_out)
	);

	assign read_data = rsp_out.read_data;
	assign irq_level = rsp_out.irq_level;

	// interrupt is raised only by a counter advance, never by a register access
	a_irq_rise_on_tick : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.irq_pending) |-> $past(adv && (req_s1.op == OP_TICK)))
		else $error("interrupt raised without a tick");

	// a disabled timer never raises the interrupt
	a_irq_rise_enabled : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.irq_pending) |-> $past(stat.enable))
		else $error("interrupt raised while disabled");

	// a control write always clears the interrupt
	a_ctrl_write_clears_irq : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (req_s1.op == OP_WRITE) && (req_s1.reg_index == REG_CTRL))
		|=> !stat.irq_pending)
		else $error("control write left interrupt pending");

	// a processed request always yields a response in the next cycle
	a_adv_gives_response : assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed request produced no response");

	// a request that cannot move on is kept in the input register
	a_held_request_kept : assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !adv) |=> req_valid)
		else $error("stalled request lost");

endmodule
